// ===== design/cbae_pkg.sv =====
package cbae_pkg;

	localparam int ChromW   = 16;
	localparam int PosW     = 31;
	localparam int MapqW    = 8;
	localparam int IdxW     = 32;
	localparam int LenW     = 28;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 28;
	localparam int QDepth   = 4;
	localparam int QPtrW    = $clog2(QDepth);
	localparam int RevBit   = 4;

	localparam logic [1:0] OP_HEADER = 2'd0;
	localparam logic [1:0] OP_CIGAR  = 2'd1;
	localparam logic [1:0] OP_DONE   = 2'd2;
	localparam logic [1:0] OP_SA     = 2'd3;

	localparam logic [3:0] CG_M  = 4'd0;
	localparam logic [3:0] CG_I  = 4'd1;
	localparam logic [3:0] CG_D  = 4'd2;
	localparam logic [3:0] CG_N  = 4'd3;
	localparam logic [3:0] CG_S  = 4'd4;
	localparam logic [3:0] CG_H  = 4'd5;
	localparam logic [3:0] CG_EQ = 4'd7;
	localparam logic [3:0] CG_X  = 4'd8;

	localparam logic [1:0] OR_LEFT    = 2'd0;
	localparam logic [1:0] OR_RIGHT   = 2'd1;
	localparam logic [1:0] OR_MIXED   = 2'd2;
	localparam logic [1:0] OR_UNKNOWN = 2'd3;

	localparam logic [1:0] SRC_SA   = 2'd0;
	localparam logic [1:0] SRC_CLIP = 2'd1;
	localparam logic [1:0] SRC_INS  = 2'd2;
	localparam logic [1:0] SRC_DEL  = 2'd3;

	localparam logic [CfgIdxW-1:0] REG_MIN_MAPQ = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_MIN_CLIP = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_MIN_INS  = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_MIN_DEL  = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_CHROM    = 3'd4;

	localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;

	typedef struct packed {
		logic [ChromW-1:0] chrom;
		logic [PosW-1:0]   pos;
		logic [1:0]        orient;
		logic [1:0]        src;
		logic              fwd;
		logic [MapqW-1:0]  mapq;
		logic [IdxW-1:0]   idx;
	} anchor_t;

	typedef struct packed {
		logic    pair;
		anchor_t first;
		anchor_t second;
	} job_t;

	typedef struct packed {
		logic [MapqW-1:0]  mapq_floor;
		logic [LenW-1:0]   min_clip;
		logic [LenW-1:0]   min_ins;
		logic [LenW-1:0]   min_del;
		logic [ChromW-1:0] chrom;
	} cfg_t;

	function automatic anchor_t make_anchor(input logic [ChromW-1:0] chrom,
		input logic signed [31:0] pos, input logic [1:0] orient, input logic [1:0] src,
		input logic fwd, input logic [MapqW-1:0] mapq, input logic [IdxW-1:0] idx);
		anchor_t a;
		a.chrom  = chrom;
		// Negative positions clamp to zero; larger ones are already saturated.
		a.pos    = pos[31] ? '0 : pos[PosW-1:0];
		a.orient = orient;
		a.src    = src;
		a.fwd    = fwd;
		a.mapq   = mapq;
		a.idx    = idx;
		return a;
	endfunction

endpackage

// ===== design/cbae_if.sv =====
interface cbae_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic signed [31:0] position;
	logic [15:0]        target_chrom;
	logic [7:0]         read_mapq;
	logic [15:0]        read_flags;
	logic [3:0]         cigar_code;
	logic [27:0]        cigar_length;

	modport source (output valid, op, position, target_chrom, read_mapq, read_flags,
		cigar_code, cigar_length, input ready);
	modport sink (input valid, op, position, target_chrom, read_mapq, read_flags,
		cigar_code, cigar_length, output ready);
endinterface

interface cbae_anchor_if;
	logic        valid;
	logic        ready;
	logic [15:0] anchor_chrom;
	logic [30:0] anchor_position;
	logic [1:0]  orientation;
	logic [1:0]  anchor_source;
	logic        forward_strand;
	logic [7:0]  anchor_mapq;
	logic [31:0] read_index;
	logic        last;

	modport source (output valid, anchor_chrom, anchor_position, orientation, anchor_source,
		forward_strand, anchor_mapq, read_index, last, input ready);
	modport sink (input valid, anchor_chrom, anchor_position, orientation, anchor_source,
		forward_strand, anchor_mapq, read_index, last, output ready);
endinterface

// ===== design/cbae_front.sv =====
module cbae_front import cbae_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	cbae_item_if.sink   items,
	output logic        q_push,
	output job_t        q_job,
	input  logic        q_full
);

	logic [IdxW-1:0]    counter_q, counter_d;
	logic               accepted_q, accepted_d;
	logic signed [31:0] start_q, start_d;
	logic signed [31:0] cursor_q, cursor_d;
	logic [1:0]         ops_q, ops_d;
	logic [LenW-1:0]    lead_q, lead_d;
	logic [LenW-1:0]    trail_q, trail_d;
	logic [MapqW-1:0]   mapq_q, mapq_d;
	logic               fwd_q, fwd_d;
	logic               done_q, done_d;

	logic               accept;
	logic signed [32:0] sum;
	logic signed [31:0] cursor_adv;
	logic               is_clip;
	logic               ref_consume;
	logic [LenW-1:0]    trail_eff;
	logic [1:0]         sa_orient;
	logic               e0_v, e1_v;
	anchor_t            e0, e1;

	assign items.ready = !q_full;
	assign accept      = items.valid && !q_full;

	always_comb begin
		sum = $signed({cursor_q[31], cursor_q}) + $signed({5'b0, items.cigar_length});
		cursor_adv = (sum[32:31] == 2'b01) ? POS_MAX : sum[31:0];
		is_clip = (items.cigar_code == CG_S) || (items.cigar_code == CG_H);
		ref_consume = (items.cigar_code == CG_M) || (items.cigar_code == CG_D) ||
			(items.cigar_code == CG_N) || (items.cigar_code == CG_EQ) ||
			(items.cigar_code == CG_X);
		trail_eff = (ops_q == 2'd2) ? trail_q : '0;
		if (cfg.chrom != items.target_chrom) begin
			sa_orient = OR_UNKNOWN;
		end else if (items.position < start_q) begin
			sa_orient = OR_LEFT;
		end else if (items.position > cursor_q) begin
			sa_orient = OR_RIGHT;
		end else begin
			sa_orient = OR_MIXED;
		end

		counter_d  = counter_q;
		accepted_d = accepted_q;
		start_d    = start_q;
		cursor_d   = cursor_q;
		ops_d      = ops_q;
		lead_d     = lead_q;
		trail_d    = trail_q;
		mapq_d     = mapq_q;
		fwd_d      = fwd_q;
		done_d     = done_q;
		e0_v       = 1'b0;
		e1_v       = 1'b0;
		e0         = '0;
		e1         = '0;

		case (items.op)
			OP_HEADER: begin
				counter_d  = counter_q + 1'b1;
				accepted_d = items.read_mapq >= cfg.mapq_floor;
				start_d    = items.position;
				cursor_d   = items.position;
				ops_d      = '0;
				lead_d     = '0;
				trail_d    = '0;
				mapq_d     = items.read_mapq;
				fwd_d      = !items.read_flags[RevBit];
				done_d     = 1'b0;
			end
			OP_CIGAR: begin
				if (accepted_q && !done_q) begin
					if (ops_q == 2'd0 && is_clip) begin
						lead_d = items.cigar_length;
					end
					trail_d = is_clip ? items.cigar_length : '0;
					if (items.cigar_code == CG_I && items.cigar_length >= cfg.min_ins) begin
						e0_v = 1'b1;
						e0 = make_anchor(cfg.chrom, cursor_q, OR_UNKNOWN, SRC_INS,
							fwd_q, mapq_q, counter_q);
					end
					if (items.cigar_code == CG_D && items.cigar_length >= cfg.min_del) begin
						e0_v = 1'b1;
						e0 = make_anchor(cfg.chrom, cursor_q, OR_UNKNOWN, SRC_DEL,
							fwd_q, mapq_q, counter_q);
						// A deletion longer than twice the threshold also anchors its end.
						if ({1'b0, items.cigar_length} > {cfg.min_del, 1'b0}) begin
							e1_v = 1'b1;
							e1 = make_anchor(cfg.chrom, cursor_adv, OR_UNKNOWN, SRC_DEL,
								fwd_q, mapq_q, counter_q);
						end
					end
					if (ref_consume) begin
						cursor_d = cursor_adv;
					end
					if (ops_q != 2'd2) begin
						ops_d = ops_q + 1'b1;
					end
				end
			end
			OP_DONE: begin
				if (accepted_q && !done_q) begin
					done_d = 1'b1;
					if (ops_q == 2'd0) begin
						if (!start_q[31]) begin
							e0_v = 1'b1;
							e0 = make_anchor(cfg.chrom, start_q, OR_UNKNOWN, SRC_SA,
								fwd_q, mapq_q, counter_q);
						end
					end else begin
						// A single op cannot be both the leading and the trailing clip.
						trail_d = trail_eff;
						if (lead_q >= cfg.min_clip) begin
							e0_v = 1'b1;
							e0 = make_anchor(cfg.chrom, start_q, OR_RIGHT, SRC_CLIP,
								fwd_q, mapq_q, counter_q);
						end
						if (trail_eff >= cfg.min_clip) begin
							e1_v = 1'b1;
							e1 = make_anchor(cfg.chrom, cursor_q, OR_LEFT, SRC_CLIP,
								fwd_q, mapq_q, counter_q);
						end
					end
				end
			end
			OP_SA: begin
				if (accepted_q && done_q && ops_q != 2'd0) begin
					e0_v = 1'b1;
					e0 = make_anchor(items.target_chrom, items.position, sa_orient, SRC_SA,
						fwd_q, mapq_q, counter_q);
					if (items.target_chrom != cfg.chrom) begin
						e1_v = 1'b1;
						e1 = make_anchor(cfg.chrom, (lead_q >= trail_q) ? start_q : cursor_q,
							OR_MIXED, SRC_SA, fwd_q, mapq_q, counter_q);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		q_push       = accept && (e0_v || e1_v);
		q_job.pair   = e0_v && e1_v;
		q_job.first  = e0_v ? e0 : e1;
		q_job.second = e1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q  <= '1;
			accepted_q <= 1'b0;
			start_q    <= '0;
			cursor_q   <= '0;
			ops_q      <= '0;
			lead_q     <= '0;
			trail_q    <= '0;
			mapq_q     <= '0;
			fwd_q      <= 1'b0;
			done_q     <= 1'b0;
		end else if (accept) begin
			counter_q  <= counter_d;
			accepted_q <= accepted_d;
			start_q    <= start_d;
			cursor_q   <= cursor_d;
			ops_q      <= ops_d;
			lead_q     <= lead_d;
			trail_q    <= trail_d;
			mapq_q     <= mapq_d;
			fwd_q      <= fwd_d;
			done_q     <= done_d;
		end
	end

endmodule

// ===== design/cbae_queue.sv =====
module cbae_queue import cbae_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wdata,
	output logic full,
	input  logic pop,
	output job_t rdata,
	output logic empty
);

	job_t             mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QPtrW:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == QDepth[QPtrW:0]);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/cbae_back.sv =====
module cbae_back import cbae_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  job_t          q_job,
	input  logic          q_empty,
	output logic          q_pop,
	cbae_anchor_if.source anchors
);

	logic    valid_q;
	logic    phase_q;
	anchor_t anchor_q;
	logic    last_q;
	logic    load;

	assign load  = (!valid_q || anchors.ready) && !q_empty;
	// A paired job stays at the head until its second anchor is loaded.
	assign q_pop = load && (phase_q || !q_job.pair);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				phase_q <= !phase_q && q_job.pair;
			end else if (anchors.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			anchor_q <= phase_q ? q_job.second : q_job.first;
			last_q   <= phase_q || !q_job.pair;
		end
	end

	assign anchors.valid           = valid_q;
	assign anchors.anchor_chrom    = anchor_q.chrom;
	assign anchors.anchor_position = anchor_q.pos;
	assign anchors.orientation     = anchor_q.orient;
	assign anchors.anchor_source   = anchor_q.src;
	assign anchors.forward_strand  = anchor_q.fwd;
	assign anchors.anchor_mapq     = anchor_q.mapq;
	assign anchors.read_index      = anchor_q.idx;
	assign anchors.last            = last_q;

endmodule

// ===== design/cigar_breakpoint_anchor_extractor_core.sv =====
// Channel   Direction  Handshake     Carries
// items     in         valid/ready   header, cigar op, done or SA target of one read
// anchors   out        valid/ready   one breakpoint anchor, last marks the final one
// cfg       in         cfg_we        thresholds and chromosome, indexed by cfg_index
//
// An input request is taken every cycle while the four-entry job queue has room.
// Items that produce two anchors send them one after the other through the output
// register, which limits the sustained anchor rate. An item's anchors pass through
// the job queue and then the output register before they are presented.
// Reset clears read state and restores the register defaults; anchors back-pressure
// the queue, and a full queue stalls the front, which then holds its read state.
module cigar_breakpoint_anchor_extractor_core import cbae_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	cbae_item_if.sink           items,
	cbae_anchor_if.source       anchors,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	cfg_t cfg_q;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	job_t q_wjob;
	job_t q_rjob;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mapq_floor <= 8'd20;
			cfg_q.min_clip   <= 28'd20;
			cfg_q.min_ins    <= 28'd50;
			cfg_q.min_del    <= 28'd50;
			cfg_q.chrom      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_MAPQ: cfg_q.mapq_floor <= cfg_data[MapqW-1:0];
				REG_MIN_CLIP: cfg_q.min_clip   <= cfg_data[LenW-1:0];
				REG_MIN_INS:  cfg_q.min_ins    <= cfg_data[LenW-1:0];
				REG_MIN_DEL:  cfg_q.min_del    <= cfg_data[LenW-1:0];
				REG_CHROM:    cfg_q.chrom      <= cfg_data[ChromW-1:0];
				default: begin
				end
			endcase
		end
	end

	cbae_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.items  (items),
		.q_push (q_push),
		.q_job  (q_wjob),
		.q_full (q_full)
	);

	cbae_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wjob),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rjob),
		.empty  (q_empty)
	);

	cbae_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_job   (q_rjob),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.anchors (anchors)
	);

	// A header request only loads read state and never queues anchors.
	a_header_no_job: assert property (@(posedge clk) disable iff (!arst_n)
		(items.valid && items.ready && items.op == OP_HEADER) |-> !q_push)
		else $error("header request queued a job");

	// The second anchor of a pair follows the first at once.
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(anchors.valid && anchors.ready && !anchors.last) |=> anchors.valid)
		else $error("second anchor of a pair missing");

	// Both anchors of a pair come from the same read.
	a_pair_same_read: assert property (@(posedge clk) disable iff (!arst_n)
		(anchors.valid && anchors.ready && !anchors.last) |=>
		(anchors.read_index == $past(anchors.read_index)))
		else $error("paired anchors differ in read index");

	// Nothing is popped from an empty queue.
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("job popped from empty queue");

endmodule

// ===== tb/anchor_checker_pkg.sv =====
package anchor_checker_pkg;
	import cbae_pkg::*;

	localparam logic [3:0] CIGAR_PAD           = 4'd6;
	localparam logic [3:0] CIGAR_FIRST_UNKNOWN = 4'd9;
	localparam logic [3:0] CIGAR_LAST_UNKNOWN  = 4'd15;
	localparam int         SHOWN_MISMATCHES    = 10;

	typedef struct packed {
		logic [1:0]        op;
		logic signed [31:0] position;
		logic [ChromW-1:0] target_chrom;
		logic [MapqW-1:0]  read_mapq;
		logic [15:0]       read_flags;
		logic [3:0]        cigar_code;
		logic [LenW-1:0]   cigar_length;
	} item_req_t;

	typedef struct packed {
		logic [ChromW-1:0] chrom;
		logic [PosW-1:0]   pos;
		logic [1:0]        orient;
		logic [1:0]        src;
		logic              fwd;
		logic [MapqW-1:0]  mapq;
		logic [IdxW-1:0]   idx;
		logic              last;
	} anchor_rec_t;

	class anchor_checker;
		logic [MapqW-1:0]  mapq_floor = 8'd20;
		logic [LenW-1:0]   min_clip = 28'd20;
		logic [LenW-1:0]   min_ins  = 28'd50;
		logic [LenW-1:0]   min_del  = 28'd50;
		logic [ChromW-1:0] chrom_id = '0;

		logic [IdxW-1:0]  read_ordinal = '1;
		bit               read_ok;
		longint           start_pos;
		longint           cursor;
		int               ops_seen;
		logic [LenW-1:0]  lead_clip;
		logic [LenW-1:0]  trail_clip;
		logic [MapqW-1:0] held_mapq;
		bit               held_fwd;
		bit               done_seen;

		anchor_rec_t pending_anchors[$];
		anchor_rec_t fresh[$];
		int          mismatches;

		function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
			case (idx)
				REG_MIN_MAPQ: mapq_floor = val[MapqW-1:0];
				REG_MIN_CLIP: min_clip = val[LenW-1:0];
				REG_MIN_INS:  min_ins  = val[LenW-1:0];
				REG_MIN_DEL:  min_del  = val[LenW-1:0];
				REG_CHROM:    chrom_id = val[ChromW-1:0];
				default: ;
			endcase
		endfunction

		function longint clamp_top(longint v);
			return v > longint'(POS_MAX) ? longint'(POS_MAX) : v;
		endfunction

		function void add_anchor(logic [ChromW-1:0] chrom, longint pos, logic [1:0] orient,
			logic [1:0] src);
			anchor_rec_t a;
			longint p;
			p = pos < 0 ? 0 : clamp_top(pos);
			a.chrom  = chrom;
			a.pos    = p[PosW-1:0];
			a.orient = orient;
			a.src    = src;
			a.fwd    = held_fwd;
			a.mapq   = held_mapq;
			a.idx    = read_ordinal;
			a.last   = 1'b0;
			fresh = {fresh, a};
		endfunction

		// Returns 1 when the request changes the read state or produces anchors.
		function bit take_request(item_req_t r);
			longint pos;
			longint len;
			bit clip;
			logic [1:0] orient;
			pos = longint'($signed(r.position));
			len = longint'(r.cigar_length);
			fresh.delete();
			if (r.op == OP_HEADER) begin
				read_ordinal++;
				read_ok    = r.read_mapq >= mapq_floor;
				start_pos  = pos;
				cursor     = pos;
				ops_seen   = 0;
				lead_clip  = '0;
				trail_clip = '0;
				held_mapq  = r.read_mapq;
				held_fwd   = !r.read_flags[RevBit];
				done_seen  = 1'b0;
				return 1'b1;
			end
			if (!read_ok)
				return 1'b0;
			case (r.op)
				OP_CIGAR: begin
					if (done_seen)
						return 1'b0;
					clip = r.cigar_code == CG_S || r.cigar_code == CG_H;
					if (ops_seen == 0 && clip)
						lead_clip = r.cigar_length;
					trail_clip = clip ? r.cigar_length : '0;
					if (r.cigar_code == CG_I && r.cigar_length >= min_ins)
						add_anchor(chrom_id, cursor, OR_UNKNOWN, SRC_INS);
					if (r.cigar_code == CG_D && r.cigar_length >= min_del) begin
						add_anchor(chrom_id, cursor, OR_UNKNOWN, SRC_DEL);
						// A deletion longer than twice the threshold also marks its far end.
						if (len > 2 * longint'(min_del))
							add_anchor(chrom_id, clamp_top(cursor + len), OR_UNKNOWN, SRC_DEL);
					end
					if (r.cigar_code inside {CG_M, CG_D, CG_N, CG_EQ, CG_X})
						cursor = clamp_top(cursor + len);
					if (ops_seen < 2)
						ops_seen++;
				end
				OP_DONE: begin
					if (done_seen)
						return 1'b0;
					done_seen = 1'b1;
					if (ops_seen == 0) begin
						if (start_pos >= 0)
							add_anchor(chrom_id, start_pos, OR_UNKNOWN, SRC_SA);
					end else begin
						// A single clip op is a leading clip only.
						if (ops_seen < 2)
							trail_clip = '0;
						if (lead_clip >= min_clip)
							add_anchor(chrom_id, start_pos, OR_RIGHT, SRC_CLIP);
						if (trail_clip >= min_clip)
							add_anchor(chrom_id, cursor, OR_LEFT, SRC_CLIP);
					end
				end
				default: begin
					if (!done_seen || ops_seen == 0)
						return 1'b0;
					orient = OR_UNKNOWN;
					if (r.target_chrom == chrom_id) begin
						if (pos < start_pos)
							orient = OR_LEFT;
						else if (pos > cursor)
							orient = OR_RIGHT;
						else
							orient = OR_MIXED;
					end
					add_anchor(r.target_chrom, pos, orient, SRC_SA);
					if (r.target_chrom != chrom_id)
						add_anchor(chrom_id, lead_clip >= trail_clip ? start_pos : cursor,
							OR_MIXED, SRC_SA);
				end
			endcase
			if (fresh.size() > 0)
				fresh[fresh.size() - 1].last = 1'b1;
			pending_anchors = {pending_anchors, fresh};
			return 1'b1;
		endfunction

		function string show(anchor_rec_t a);
			return $sformatf("chrom=%0d pos=%0d orient=%0d src=%0d fwd=%0d mapq=%0d idx=%0d last=%0d",
				a.chrom, a.pos, a.orient, a.src, a.fwd, a.mapq, a.idx, a.last);
		endfunction

		function void check_anchor(anchor_rec_t got);
			anchor_rec_t want;
			if (pending_anchors.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES)
					$display("unexpected anchor: %s", show(got));
				return;
			end
			want = pending_anchors.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES) begin
					$display("anchor mismatch");
					$display("  expected %s", show(want));
					$display("  actual   %s", show(got));
				end
			end
		endfunction
	endclass

endpackage

// ===== tb/tb_top.sv =====
module tb_top import cbae_pkg::*, anchor_checker_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	int send_idle_pct;
	int take_idle_pct;
	int counted;
	anchor_checker book = new();

	cbae_item_if   items();
	cbae_anchor_if anchors();

	cigar_breakpoint_anchor_extractor_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.items(items),
		.anchors(anchors),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic item_req_t req_noise();
		item_req_t r;
		r.op           = 2'($urandom_range(0, 3));
		r.position     = $urandom;
		r.target_chrom = 16'($urandom);
		r.read_mapq    = 8'($urandom);
		r.read_flags   = 16'($urandom);
		r.cigar_code   = 4'($urandom);
		r.cigar_length = LenW'($urandom);
		return r;
	endfunction

	function automatic item_req_t req_header(logic signed [31:0] pos, logic [7:0] mapq,
		logic [15:0] flags);
		item_req_t r = req_noise();
		r.op         = OP_HEADER;
		r.position   = pos;
		r.read_mapq  = mapq;
		r.read_flags = flags;
		return r;
	endfunction

	function automatic item_req_t req_cigar(logic [3:0] code, logic [LenW-1:0] len);
		item_req_t r = req_noise();
		r.op           = OP_CIGAR;
		r.cigar_code   = code;
		r.cigar_length = len;
		return r;
	endfunction

	function automatic item_req_t req_done();
		item_req_t r = req_noise();
		r.op = OP_DONE;
		return r;
	endfunction

	function automatic item_req_t req_sa(logic [15:0] chrom, logic signed [31:0] pos);
		item_req_t r = req_noise();
		r.op           = OP_SA;
		r.target_chrom = chrom;
		r.position     = pos;
		return r;
	endfunction

	function automatic logic [3:0] pick_code();
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5: return CG_M;
			6, 7:             return CG_S;
			8, 9:             return CG_H;
			10, 11:           return CG_I;
			12, 13:           return CG_D;
			14:               return CG_N;
			15:               return CG_EQ;
			16:               return CG_X;
			17:               return CIGAR_PAD;
			default:          return 4'($urandom_range(CIGAR_FIRST_UNKNOWN, CIGAR_LAST_UNKNOWN));
		endcase
	endfunction

	// Lengths cluster around whichever threshold applies to the op.
	function automatic logic [LenW-1:0] pick_len(logic [3:0] code);
		logic [LenW-1:0] thr;
		thr = code == CG_I ? book.min_ins : code == CG_D ? book.min_del :
			(code == CG_S || code == CG_H) ? book.min_clip : '0;
		case ($urandom_range(0, 9))
			0:       return thr;
			1:       return thr - 1'b1;
			2:       return (thr << 1) + LenW'($urandom_range(0, 1));
			3:       return LenW'($urandom);
			4:       return '0;
			default: return LenW'($urandom_range(0, 300));
		endcase
	endfunction

	task automatic send_request(item_req_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			items.valid <= 1'b0;
			@(posedge clk);
		end
		items.valid        <= 1'b1;
		items.op           <= r.op;
		items.position     <= r.position;
		items.target_chrom <= r.target_chrom;
		items.read_mapq    <= r.read_mapq;
		items.read_flags   <= r.read_flags;
		items.cigar_code   <= r.cigar_code;
		items.cigar_length <= r.cigar_length;
		do
			@(posedge clk);
		while (!items.ready);
		void'(book.take_request(r));
		counted++;
	endtask

	// Stop sending and let every expected anchor, and any request still in flight, clear.
	task automatic drain();
		items.valid <= 1'b0;
		while (book.pending_anchors.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_config(logic [7:0] mq, logic [LenW-1:0] clip, logic [LenW-1:0] ins,
		logic [LenW-1:0] del, logic [15:0] chrom);
		logic [CfgIdxW-1:0]  idx[5];
		logic [CfgDataW-1:0] val[5];
		idx = '{REG_MIN_MAPQ, REG_MIN_CLIP, REG_MIN_INS, REG_MIN_DEL, REG_CHROM};
		val = '{CfgDataW'(mq), clip, ins, del, CfgDataW'(chrom)};
		for (int i = 0; i < 5; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			book.set_reg(idx[i], val[i]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic random_read();
		int              n_ops;
		logic [3:0]      code;
		logic [7:0]      mq;
		logic signed [31:0] pos;
		longint          sa_pos;
		logic [15:0]     sa_chrom;
		case ($urandom_range(0, 3))
			0:       mq = book.mapq_floor;
			1:       mq = book.mapq_floor - 1'b1;
			default: mq = 8'($urandom);
		endcase
		case ($urandom_range(0, 19))
			0:       pos = -1;
			1:       pos = $urandom;
			2, 3:    pos = POS_MAX - $urandom_range(0, 3000);
			4:       pos = 0;
			default: pos = $urandom_range(0, 200000);
		endcase
		send_request(req_header(pos, mq, 16'($urandom)));
		n_ops = $urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 6);
		for (int i = 0; i < n_ops; i++) begin
			code = pick_code();
			send_request(req_cigar(code, pick_len(code)));
		end
		// Now and then the done request is missing, so SA targets must be ignored.
		if ($urandom_range(0, 19) != 0)
			send_request(req_done());
		repeat ($urandom_range(0, 3)) begin
			case ($urandom_range(0, 5))
				0:       sa_pos = book.start_pos - 1;
				1:       sa_pos = book.start_pos;
				2:       sa_pos = book.cursor;
				3:       sa_pos = book.cursor + 1;
				4:       sa_pos = $urandom;
				default: sa_pos = book.start_pos + $urandom_range(0, 500);
			endcase
			sa_chrom = $urandom_range(0, 2) == 0 ? 16'($urandom) : book.chrom_id;
			send_request(req_sa(sa_chrom, sa_pos[31:0]));
		end
		if ($urandom_range(0, 9) == 0)
			send_request(req_noise());
	endtask

	initial begin
		anchor_rec_t got;
		anchors.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && anchors.valid && anchors.ready) begin
				got.chrom  = anchors.anchor_chrom;
				got.pos    = anchors.anchor_position;
				got.orient = anchors.orientation;
				got.src    = anchors.anchor_source;
				got.fwd    = anchors.forward_strand;
				got.mapq   = anchors.anchor_mapq;
				got.idx    = anchors.read_index;
				got.last   = anchors.last;
				book.check_anchor(got);
			end
			anchors.ready <= $urandom_range(0, 99) >= take_idle_pct;
		end
	end

	initial begin
		item_req_t directed[$];
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= REG_MIN_MAPQ;
		cfg_data           <= '0;
		items.valid        <= 1'b0;
		items.op           <= OP_HEADER;
		items.position     <= '0;
		items.target_chrom <= '0;
		items.read_mapq    <= '0;
		items.read_flags   <= '0;
		items.cigar_code   <= CG_M;
		items.cigar_length <= '0;
		send_idle_pct = 11;
		take_idle_pct = 63;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset thresholds: mapq 20, clip 20, insertion 50, deletion 50, chromosome 0.
		directed = '{
			req_header(1000, 60, 16'h0000),
			req_cigar(CG_S, 30),
			req_cigar(CG_M, 100),
			req_cigar(CG_I, 60),
			req_cigar(CG_D, 120),
			req_cigar(CG_D, 50),
			req_cigar(CG_N, 10),
			req_cigar(CIGAR_LAST_UNKNOWN, 7),
			req_cigar(CG_H, 25),
			req_sa(16'd0, 500),
			req_done(),
			req_done(),
			req_cigar(CG_I, 100),
			req_sa(16'd0, 10),
			req_sa(16'd0, 5000),
			req_sa(16'hFFFF, 0),
			req_header(5000, 5, 16'hFFFF),
			req_cigar(CG_I, 28'hFFFFFFF),
			req_header(-1, 8'hFF, 16'h0010),
			req_done(),
			req_sa(16'd0, 7),
			req_header(POS_MAX - 10, 20, 16'h0000),
			req_cigar(CG_M, 28'hFFFFFFF),
			req_cigar(CG_D, 28'hFFFFFFF),
			req_cigar(CG_S, 100),
			req_done(),
			req_header(42, 30, 16'h0000),
			req_done()
		};
		foreach (directed[i])
			send_request(directed[i]);
		drain();

		for (int seg = 0; seg < 6; seg++) begin
			send_idle_pct = seg < 2 ? 11 : seg < 4 ? 63 : 0;
			take_idle_pct = seg < 2 ? 63 : seg < 4 ? 11 : 0;
			case (seg)
				0: write_config(8'($urandom_range(10, 40)), LenW'($urandom_range(5, 40)),
					LenW'($urandom_range(20, 80)), LenW'($urandom_range(20, 80)), 16'd7);
				1: write_config(8'd0, '0, '0, '0, 16'hFFFF);
				2: write_config(8'hFF, '1, '1, '1, 16'h0000);
				3: write_config(8'($urandom_range(0, 60)), LenW'($urandom_range(1, 100)),
					LenW'($urandom_range(1, 100)), LenW'($urandom_range(1, 100)),
					16'($urandom));
				4: write_config(8'd1, 28'd1, 28'd1, 28'd1, 16'd1);
				default: write_config(8'd30, 28'd15, 28'd40, 28'd40, 16'h8000);
			endcase
			while (counted < (seg + 1) * 260)
				random_read();
			// The sender holds off here until every expected anchor has come back.
			drain();
		end

		if (book.mismatches == 0 && book.pending_anchors.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/cbae_pkg.sv
design/cbae_if.sv
design/cbae_front.sv
design/cbae_queue.sv
design/cbae_back.sv
design/cigar_breakpoint_anchor_extractor_core.sv
tb/anchor_checker_pkg.sv
tb/tb_top.sv
